>>> rtl/smp_pkg.sv
// Package for the segmented MMU memory port.
// Holds codes, sequencer states, the decode struct and fixed constants.
`timescale 1ns / 1ps
package smp_pkg;

  localparam int unsigned PhysAddrBits   = 20;
  localparam int unsigned IdRegAddr      = 16;
  localparam int unsigned SerialDataAddr = 192;
  localparam int unsigned PageShift      = 12;

  localparam logic [1:0] SPACE_MEM = 2'd0;
  localparam logic [1:0] SPACE_INT = 2'd1;

  localparam logic CMD_WRITE = 1'b1;
  localparam logic SIZE_WORD = 1'b1;

  localparam logic [1:0] CFG_SEG_SIZE  = 2'd0;
  localparam logic [1:0] CFG_STACK_SEG = 2'd1;
  localparam logic [1:0] CFG_DATA_SEG  = 2'd2;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_HI,
    ST_FIN
  } smp_state_e;

  typedef struct packed {
    logic is_mem;
    logic id_load;
    logic ser_hit;
  } smp_ctl_t;

endpackage

>>> rtl/smp_ram.sv
// Generic single-port synchronous RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module smp_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     en_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] addr_i,
  input  logic [Width-1:0]         wdata_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      if (we_i) begin
        mem_q[addr_i] <= wdata_i;
      end else begin
        rdata_q <= mem_q[addr_i];
      end
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> rtl/smp_xlate.sv
// Address translation and I/O decode for one access beat.
// Depends on smp_pkg.
`timescale 1ns / 1ps
module smp_xlate import smp_pkg::*; #(
  parameter int unsigned PhysBits = PhysAddrBits
) (
  input  logic [1:0]          io_space_i,
  input  logic                command_i,
  input  logic                word_size_i,
  input  logic [15:0]         address_i,
  input  logic [7:0]          window_page_i,
  input  logic [7:0]          segment_size_i,
  input  logic [7:0]          stack_segment_i,
  input  logic [7:0]          data_segment_i,
  input  logic [7:0]          id_reg_i,
  output logic [PhysBits-1:0] phys_o,
  output smp_ctl_t            ctl_o
);

  localparam int unsigned HiBits = PhysBits - PageShift;

  logic [3:0]        nib;
  logic [7:0]        page;
  logic [HiBits-1:0] hi_sum;
  logic [15:0]       io_addr;

  always_comb begin
    nib = address_i[15:12];
    if (nib >= 4'hE) begin
      page = window_page_i;
    end else if (nib >= segment_size_i[7:4]) begin
      page = stack_segment_i;
    end else if (nib >= segment_size_i[3:0]) begin
      page = data_segment_i;
    end else begin
      page = 8'h00;
    end
    hi_sum = HiBits'(nib) + HiBits'(page);
    phys_o = {hi_sum, address_i[PageShift-1:0]};
  end

  always_comb begin
    io_addr = id_reg_i[7] ? address_i : {8'h00, address_i[7:0]};
    ctl_o.is_mem  = (io_space_i == SPACE_MEM);
    ctl_o.id_load = 1'b0;
    ctl_o.ser_hit = 1'b0;
    if (io_space_i == SPACE_INT && command_i == CMD_WRITE && word_size_i != SIZE_WORD) begin
      if (io_addr == 16'(IdRegAddr)) begin
        ctl_o.id_load = 1'b1;
      end else if (io_addr == 16'(SerialDataAddr)) begin
        ctl_o.ser_hit = 1'b1;
      end
    end
  end

endmodule

>>> rtl/segmented_mmu_memory_port_top.sv
// Results load into the output registers in ST_FIN; words first pass ST_HI. One byte
// or I/O beat is taken per cycle unless the output stalls; a word stalls the input in
// ST_HI (single port of byte-wide memory); the next beat enters while a result waits.
// Reset clears control, configuration and the ID register; memory is not cleared.
// Depends on smp_pkg, smp_xlate and smp_ram.
`timescale 1ns / 1ps
module segmented_mmu_memory_port_top import smp_pkg::*; #(
  parameter int unsigned PhysBits = PhysAddrBits
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic        command_i,
  input  logic        word_size_i,
  input  logic [1:0]  io_space_i,
  input  logic [15:0] address_i,
  input  logic [15:0] write_data_i,
  input  logic [7:0]  window_page_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [15:0] read_data_o,
  output logic        serial_valid_o,
  output logic [7:0]  serial_byte_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [7:0]  cfg_data_i
);

  smp_state_e state_q, state_d;

  logic [7:0]          seg_size_q, stack_seg_q, data_seg_q, id_q;
  logic                is_word_q, is_read_q, sval_q;
  logic [7:0]          sbyte_q, wdata_hi_q, lo_q;
  logic [PhysBits-1:0] p1_q;
  logic                out_valid_q, out_sval_q;
  logic [15:0]         out_rd_q;
  logic [7:0]          out_sbyte_q;

  logic [PhysBits-1:0] phys;
  smp_ctl_t            ctl;
  logic                in_acc, out_free, out_load;
  logic                ram_en, ram_we;
  logic [PhysBits-1:0] ram_addr;
  logic [7:0]          ram_wdata, ram_rdata;
  logic [15:0]         result_rd;

  smp_xlate #(.PhysBits(PhysBits)) u_xlate (
    .io_space_i     (io_space_i),
    .command_i      (command_i),
    .word_size_i    (word_size_i),
    .address_i      (address_i),
    .window_page_i  (window_page_i),
    .segment_size_i (seg_size_q),
    .stack_segment_i(stack_seg_q),
    .data_segment_i (data_seg_q),
    .id_reg_i       (id_q),
    .phys_o         (phys),
    .ctl_o          (ctl)
  );

  smp_ram #(.Width(8), .Depth(2 ** PhysBits)) u_ram (
    .clk_i  (clk_i),
    .en_i   (ram_en),
    .we_i   (ram_we),
    .addr_i (ram_addr),
    .wdata_i(ram_wdata),
    .rdata_o(ram_rdata)
  );

  assign cfg_ready_o = 1'b1;
  assign out_free    = !out_valid_q || !out_stall_i;
  assign in_stall_o  = !(state_q == ST_IDLE || (state_q == ST_FIN && out_free));
  assign in_acc      = in_valid_i && !in_stall_o;
  assign out_load    = (state_q == ST_FIN) && out_free;

  always_comb begin
    ram_en    = 1'b0;
    ram_we    = 1'b0;
    ram_addr  = phys;
    ram_wdata = write_data_i[7:0];
    if (in_acc && ctl.is_mem) begin
      ram_en = 1'b1;
      ram_we = (command_i == CMD_WRITE);
    end else if (state_q == ST_HI) begin
      ram_en    = 1'b1;
      ram_we    = !is_read_q;
      ram_addr  = p1_q;
      ram_wdata = wdata_hi_q;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: state_d = ST_IDLE;
      ST_HI:   state_d = ST_FIN;
      ST_FIN:  state_d = out_free ? ST_IDLE : ST_FIN;
      default: state_d = ST_IDLE;
    endcase
    if (in_acc) begin
      state_d = (ctl.is_mem && word_size_i == SIZE_WORD) ? ST_HI : ST_FIN;
    end
  end

  always_comb begin
    if (!is_read_q) begin
      result_rd = 16'h0000;
    end else if (is_word_q) begin
      result_rd = {ram_rdata, lo_q};
    end else begin
      result_rd = {8'h00, ram_rdata};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
      seg_size_q  <= 8'h00;
      stack_seg_q <= 8'h00;
      data_seg_q  <= 8'h00;
      id_q        <= 8'h00;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_load || (out_valid_q && out_stall_i);
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          CFG_SEG_SIZE:  seg_size_q  <= cfg_data_i;
          CFG_STACK_SEG: stack_seg_q <= cfg_data_i;
          CFG_DATA_SEG:  data_seg_q  <= cfg_data_i;
          default:       ;
        endcase
      end
      if (in_acc && ctl.id_load) begin
        id_q <= write_data_i[7:0];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      is_word_q  <= (word_size_i == SIZE_WORD);
      is_read_q  <= ctl.is_mem && (command_i != CMD_WRITE);
      p1_q       <= phys + PhysBits'(1);
      wdata_hi_q <= write_data_i[15:8];
      sval_q     <= ctl.ser_hit;
      sbyte_q    <= ctl.ser_hit ? write_data_i[7:0] : 8'h00;
    end
    if (state_q == ST_HI) begin
      lo_q <= ram_rdata;
    end
    if (out_load) begin
      out_rd_q    <= result_rd;
      out_sval_q  <= sval_q;
      out_sbyte_q <= sbyte_q;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign read_data_o    = out_rd_q;
  assign serial_valid_o = out_sval_q;
  assign serial_byte_o  = out_sbyte_q;

endmodule

>>> rtl/smp_checker.sv
// Port-level assertions for the segmented MMU memory port, bound to the top level.
// Depends on smp_pkg.
`timescale 1ns / 1ps
module smp_checker import smp_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_stall_o,
  input logic        word_size_i,
  input logic [1:0]  io_space_i,
  input logic        out_valid_o,
  input logic        out_stall_i,
  input logic [15:0] read_data_o,
  input logic        serial_valid_o,
  input logic [7:0]  serial_byte_o
);

  a_serial_no_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && serial_valid_o |-> read_data_o == 16'h0000)
    else $error("serial beat carries read data");

  a_byte_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !serial_valid_o |-> serial_byte_o == 8'h00)
    else $error("serial byte without serial valid");

  a_word_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && io_space_i == SPACE_MEM && word_size_i == SIZE_WORD
    |=> in_stall_o)
    else $error("word access not held for second byte");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(read_data_o))
    else $error("stalled result dropped or changed");

endmodule

bind segmented_mmu_memory_port_top smp_checker u_smp_checker (.*);
